>>> hw/rtl/pec_pkg.sv
package pec_pkg;

  localparam int KeyW   = 64;
  localparam int CountW = 4;
  localparam int IdW    = 8;
  localparam int NumIds = 8;
  localparam int HitsW  = 32;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_RECORD = 1'b1
  } cmd_t;

  typedef struct packed {
    logic              command;
    logic [KeyW-1:0]   key_hash;
    logic [CountW-1:0] id_count;
    logic [IdW-1:0]    expert_id_0;
    logic [IdW-1:0]    expert_id_1;
    logic [IdW-1:0]    expert_id_2;
    logic [IdW-1:0]    expert_id_3;
    logic [IdW-1:0]    expert_id_4;
    logic [IdW-1:0]    expert_id_5;
    logic [IdW-1:0]    expert_id_6;
    logic [IdW-1:0]    expert_id_7;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [CountW-1:0] found_count;
    logic [IdW-1:0]    expert_id;
    logic              last;
  } out_item_t;

endpackage

>>> hw/rtl/pec_ram.sv
module pec_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/pec_front.sv
module pec_front import pec_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     q_valid,
  input  logic     q_stall,
  output in_item_t q_item
);

  // Two-entry queue; records with no ids are dropped here.
  in_item_t buf0, buf1;
  logic [1:0] cnt;
  logic push, pop, keep;

  assign in_stall = (cnt == 2'd2);
  assign keep     = !(in_item.command == CMD_RECORD && in_item.id_count == '0);
  assign push     = in_valid && !in_stall && keep;
  assign pop      = q_valid && !q_stall;
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (pop) begin
      buf0 <= (push && cnt == 2'd1) ? in_item : buf1;
    end else if (push && cnt == 2'd0) begin
      buf0 <= in_item;
    end
    if (push && ((cnt == 2'd1 && !pop) || (cnt == 2'd2 && pop))) begin
      buf1 <= in_item;
    end
  end

endmodule

>>> hw/rtl/pec_back.sv
module pec_back import pec_pkg::*; #(
  parameter int Capacity = 16,
  parameter int MaxIds   = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_stall,
  input  in_item_t  q_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int AW  = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int FW  = $clog2(Capacity + 1);
  localparam int IW  = (MaxIds > 1) ? $clog2(MaxIds) : 1;
  localparam int IAW = $clog2(Capacity * MaxIds);
  localparam int LenW = $clog2(MaxIds + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_VICT  = 7'b0000100,
    S_WRITE = 7'b0001000,
    S_BUMP  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_t;

  state_t   state;
  in_item_t cur;
  logic [FW-1:0] fill_level;
  logic [FW-1:0] scan;
  logic [AW-1:0] idx;
  logic [AW-1:0] best;
  logic [HitsW-1:0] best_hits;
  logic [HitsW-1:0] cur_hits;
  logic          first_rd;
  logic [IW:0]   wcnt;
  logic [IW:0]   ecnt;
  logic [LenW-1:0] len;
  logic          rd_pending;
  logic          key_match;
  logic          out_free;
  logic          emit;

  // Memories.
  logic            key_we, len_we, hits_we, ids_we;
  logic [AW-1:0]   key_wa, hits_wa, rd_a;
  logic [KeyW-1:0] key_rd;
  logic [LenW-1:0] len_rd, len_wd;
  logic [HitsW-1:0] hits_rd, hits_wd;
  logic [IAW-1:0]  ids_wa, ids_ra;
  logic [IdW-1:0]  ids_wd, ids_rd;
  logic [IdW-1:0]  in_ids [NumIds];
  logic [LenW-1:0] rec_len;

  pec_ram #(.Width(KeyW), .Depth(Capacity)) u_key (
    .clk, .wr_en(key_we), .wr_addr(key_wa), .wr_data(cur.key_hash),
    .rd_addr(rd_a), .rd_data(key_rd));
  pec_ram #(.Width(LenW), .Depth(Capacity)) u_len (
    .clk, .wr_en(len_we), .wr_addr(key_wa), .wr_data(len_wd),
    .rd_addr(rd_a), .rd_data(len_rd));
  pec_ram #(.Width(HitsW), .Depth(Capacity)) u_hits (
    .clk, .wr_en(hits_we), .wr_addr(hits_wa), .wr_data(hits_wd),
    .rd_addr(rd_a), .rd_data(hits_rd));
  pec_ram #(.Width(IdW), .Depth(Capacity * MaxIds)) u_ids (
    .clk, .wr_en(ids_we), .wr_addr(ids_wa), .wr_data(ids_wd),
    .rd_addr(ids_ra), .rd_data(ids_rd));

  assign in_ids = '{cur.expert_id_0, cur.expert_id_1, cur.expert_id_2, cur.expert_id_3,
                    cur.expert_id_4, cur.expert_id_5, cur.expert_id_6, cur.expert_id_7};
  assign rec_len = (cur.id_count > CountW'(MaxIds)) ? LenW'(MaxIds)
                                                    : LenW'(cur.id_count);
  assign len_wd  = rec_len;

  assign q_stall = (state != S_IDLE);
  assign rd_a    = scan[AW-1:0];

  // The output register can take a new result when it is empty or being drained.
  assign key_match = rd_pending && (key_rd == cur.key_hash);
  assign out_free  = !out_valid || !out_stall;
  assign emit      = out_free && ((state == S_WAIT) ||
                                  (state == S_SCAN && !key_match && scan >= fill_level &&
                                   cur.command == CMD_LOOKUP));

  // Entries are written one id a cycle; a slot beyond the length gets zero.
  assign ids_we  = (state == S_WRITE);
  assign ids_wa  = IAW'(idx) * IAW'(MaxIds) + IAW'(wcnt[IW-1:0]);
  assign ids_wd  = (LenW'(wcnt) < rec_len) ? in_ids[wcnt[IW-1:0]] : '0;
  assign key_wa  = idx;
  assign key_we  = (state == S_WRITE) && (wcnt == '0);
  assign len_we  = key_we;
  assign hits_we = key_we || (state == S_BUMP);
  assign hits_wa = idx;
  assign hits_wd = (state == S_BUMP) ? ((cur_hits == '1) ? cur_hits : cur_hits + HitsW'(1))
                                     : HitsW'(1);
  assign ids_ra  = IAW'(idx) * IAW'(MaxIds) + IAW'(ecnt[IW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_level <= '0;
      out_valid  <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur        <= q_item;
            scan       <= '0;
            rd_pending <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Read address scan issued; the registered data is compared in the next cycle.
          if (key_match) begin
            idx        <= AW'(scan - 1'b1);
            cur_hits   <= hits_rd;
            rd_pending <= 1'b0;
            if (cur.command == CMD_LOOKUP) begin
              len   <= len_rd;
              ecnt  <= '0;
              state <= S_EMIT;
            end else begin
              scan  <= FW'(scan - 1'b1);
              state <= S_BUMP;
            end
          end else if (scan >= fill_level) begin
            rd_pending <= 1'b0;
            if (cur.command == CMD_LOOKUP) begin
              if (out_free) begin
                out_item <= '{hit: 1'b0, found_count: '0, expert_id: '0, last: 1'b1};
                state    <= S_IDLE;
              end
            end else if (fill_level < FW'(Capacity)) begin
              idx        <= fill_level[AW-1:0];
              fill_level <= fill_level + 1'b1;
              wcnt       <= '0;
              state      <= S_WRITE;
            end else begin
              scan     <= '0;
              first_rd <= 1'b1;
              state    <= S_VICT;
            end
          end else begin
            scan       <= scan + 1'b1;
            rd_pending <= 1'b1;
          end
        end
        S_VICT: begin
          // Lowest hit count, lowest index on a tie.
          if (rd_pending && (first_rd || hits_rd < best_hits)) begin
            best      <= AW'(scan - 1'b1);
            best_hits <= hits_rd;
            first_rd  <= 1'b0;
          end
          if (scan == FW'(Capacity)) begin
            if (!rd_pending) begin
              scan <= scan;
            end
            if (rd_pending) begin
              rd_pending <= 1'b0;
              idx   <= (first_rd || hits_rd < best_hits) ? AW'(scan - 1'b1) : best;
              wcnt  <= '0;
              state <= S_WRITE;
            end
          end else begin
            scan       <= scan + 1'b1;
            rd_pending <= 1'b1;
          end
        end
        S_WRITE: begin
          if (wcnt == (IW+1)'(MaxIds - 1)) begin
            state <= S_IDLE;
          end
          wcnt <= wcnt + 1'b1;
        end
        S_BUMP: begin
          // cur_hits holds the matching entry's count; written back this cycle.
          state <= S_IDLE;
        end
        S_EMIT: begin
          // Issue read of id ecnt; the registered data is ready in S_WAIT.
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (out_free) begin
            out_item  <= '{hit: 1'b1, found_count: CountW'(len), expert_id: ids_rd,
                           last: (LenW'(ecnt) + 1'b1 == len)};
            ecnt      <= ecnt + 1'b1;
            state     <= (LenW'(ecnt) + 1'b1 == len) ? S_IDLE : S_EMIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/prefix_expert_cache.sv
// Channel   Struct       Handshake
// in        in_item_t    in_valid / in_stall
// out       out_item_t   out_valid / out_stall
//
// A transaction leaves the queue, then the back end scans one key per cycle; a miss is
// registered once the scan passes fill_level, and a matching entry ends the scan.
// A lookup hit then returns its ids one at a time; a repeat record bumps the hit count.
// A new record writes MAX_IDS ids, one per cycle, after a victim sweep of all CAPACITY
// entries when the table is full.
// Reset (rst, synchronous) empties the table; a stalled result holds the back end.
module prefix_expert_cache import pec_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int MAX_IDS  = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic     q_valid, q_stall;
  in_item_t q_item;

  // Front end: queues transactions and drops empty records.
  pec_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_item,
    .q_valid, .q_stall, .q_item);

  // Back end: scans, replaces and emits results one transaction at a time.
  pec_back #(.Capacity(CAPACITY), .MaxIds(MAX_IDS)) u_back (
    .clk, .rst, .q_valid, .q_stall, .q_item,
    .out_valid, .out_stall, .out_item);

endmodule

>>> hw/rtl/pec_checker.sv
module pec_checker import pec_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  ap_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("input withdrawn while stalled");

  ap_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  ap_miss_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.hit |-> out_item.last && out_item.found_count == '0 &&
      out_item.expert_id == '0)
    else $error("malformed miss result");

  ap_hit_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.hit |-> out_item.found_count != '0)
    else $error("hit with no ids");

  ap_reset_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result after reset");

endmodule

bind prefix_expert_cache pec_checker u_pec_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_item);

>>> dv/prefix_expert_cache_checker.sv
`timescale 1ns / 1ps

module prefix_expert_cache_checker import pec_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);

  localparam int Slots = 16;

  logic [KeyW-1:0]  slot_key  [Slots];
  logic [3:0]       slot_len  [Slots];
  logic [IdW-1:0]   slot_ids  [Slots][NumIds];
  logic [HitsW-1:0] slot_hits [Slots];
  int               occupied;
  out_item_t        lookup_results[$];

  assign pending = lookup_results.size();

  // Applies one accepted transaction to the table copy and queues any lookup results.
  task automatic apply_transaction(input in_item_t t);
    int        idx;
    int        n;
    out_item_t r;
    logic [IdW-1:0] ids [NumIds];
    idx = Slots;
    ids = '{t.expert_id_0, t.expert_id_1, t.expert_id_2, t.expert_id_3,
            t.expert_id_4, t.expert_id_5, t.expert_id_6, t.expert_id_7};
    for (int i = occupied - 1; i >= 0; i--)
      if (slot_key[i] == t.key_hash) idx = i;
    if (cmd_t'(t.command) == CMD_LOOKUP) begin
      if (idx == Slots) begin
        r = '{hit: 1'b0, found_count: '0, expert_id: '0, last: 1'b1};
        lookup_results.push_back(r);
      end else begin
        n = slot_len[idx];
        for (int k = 0; k < n; k++) begin
          r = '{hit: 1'b1, found_count: slot_len[idx], expert_id: slot_ids[idx][k],
                last: (k == n - 1)};
          lookup_results.push_back(r);
        end
      end
    end else if (t.id_count != 0) begin
      if (idx != Slots) begin
        if (slot_hits[idx] != '1) slot_hits[idx]++;
      end else begin
        if (occupied < Slots) begin
          idx = occupied;
          occupied++;
        end else begin
          idx = 0;
          for (int i = 1; i < Slots; i++)
            if (slot_hits[i] < slot_hits[idx]) idx = i;
        end
        n = (t.id_count > NumIds) ? NumIds : t.id_count;
        slot_key[idx]  = t.key_hash;
        slot_len[idx]  = 4'(n);
        slot_hits[idx] = 1;
        for (int k = 0; k < NumIds; k++) slot_ids[idx][k] = (k < n) ? ids[k] : '0;
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      occupied = 0;
      fail_count <= 0;
      lookup_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (lookup_results.size() == 0) begin
          $error("result transaction with no expectation: %p", out_item);
          fail_count <= fail_count + 1;
        end else begin
          want = lookup_results.pop_front();
          if (out_item != want) begin
            if (out_item.hit != want.hit)
              $error("hit: expected %0d actual %0d", want.hit, out_item.hit);
            if (out_item.found_count != want.found_count)
              $error("found_count: expected %0d actual %0d", want.found_count,
                     out_item.found_count);
            if (out_item.expert_id != want.expert_id)
              $error("expert_id: expected %0d actual %0d", want.expert_id,
                     out_item.expert_id);
            if (out_item.last != want.last)
              $error("last: expected %0d actual %0d", want.last, out_item.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) apply_transaction(in_item);
    end
  end

endmodule

>>> dv/prefix_expert_cache_test.sv
`timescale 1ns / 1ps

module prefix_expert_cache_test;
  import pec_pkg::*;

  localparam longint CycleLimit = 400000;
  localparam int     ItemW      = $bits(in_item_t);

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  longint    cycle_count;
  bit        quiet_receiver;
  int        sent;

  // A small pool of hashes makes repeats, hit counting and replacement common.
  logic [KeyW-1:0] hash_pool [24];

  prefix_expert_cache DUT (.*);

  prefix_expert_cache_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The cycle counter stops a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver stalls for a random number of cycles before each result, except
  // during a quiet stretch in which it takes every result at once.
  initial begin
    int wait_cycles;
    out_stall = 1'b1;
    @(posedge clk iff !rst);
    forever begin
      wait_cycles = quiet_receiver ? 0 : $urandom_range(0, 18);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk iff out_valid);
    end
  end

  // Builds one transaction; the ids are always random so that every id bit toggles.
  function automatic in_item_t make_transaction(cmd_t cmd, logic [KeyW-1:0] key,
                                                logic [3:0] count);
    in_item_t t;
    t = ItemW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    t.command  = cmd;
    t.key_hash = key;
    t.id_count = count;
    return t;
  endfunction

  // Presents one transaction after the given gap and holds it until accepted.
  // Valid stays high after acceptance so that back-to-back transactions follow directly.
  task automatic send_transaction(input in_item_t t, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= t;
    @(posedge clk iff !in_stall);
    sent++;
  endtask

  initial begin
    in_item_t t;
    int       pick;
    int       gap;
    in_valid       = 1'b0;
    in_item        = '0;
    rst            = 1'b1;
    cycle_count    = 0;
    quiet_receiver = 1'b0;
    sent           = 0;
    for (int i = 0; i < 24; i++) hash_pool[i] = {$urandom, $urandom};
    hash_pool[0] = '0;
    hash_pool[1] = '1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part: a miss on the empty table, the all-zero and all-ones keys,
    // a record of zero count, a count above the id limit, the maximum count,
    // a repeat record that only bumps the hit count, and lookups of each.
    send_transaction(make_transaction(CMD_LOOKUP, hash_pool[0], 4'd0), 0);
    send_transaction(make_transaction(CMD_RECORD, hash_pool[0], 4'd0), 0);
    send_transaction(make_transaction(CMD_LOOKUP, hash_pool[0], 4'd3), 0);
    send_transaction(make_transaction(CMD_RECORD, hash_pool[0], 4'd1), 0);
    send_transaction(make_transaction(CMD_RECORD, hash_pool[1], 4'd15), 1);
    send_transaction(make_transaction(CMD_RECORD, hash_pool[2], 4'd8), 0);
    send_transaction(make_transaction(CMD_RECORD, hash_pool[2], 4'd5), 0);
    send_transaction(make_transaction(CMD_LOOKUP, hash_pool[0], 4'd0), 2);
    send_transaction(make_transaction(CMD_LOOKUP, hash_pool[1], 4'd0), 0);
    send_transaction(make_transaction(CMD_LOOKUP, hash_pool[2], 4'd0), 0);
    // Fill the table and push past it so that the replacement path is taken.
    for (int i = 3; i < 20; i++)
      send_transaction(make_transaction(CMD_RECORD, hash_pool[i], 4'($urandom_range(1, 8))),
                       0);
    send_transaction(make_transaction(CMD_LOOKUP, hash_pool[3], 4'd0), 0);

    // The sender holds off until every outstanding result has arrived.
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);

    // Random part: mostly records and lookups of pooled keys, some fresh keys.
    for (int n = 0; n < 290; n++) begin
      quiet_receiver = (n >= 120 && n < 150);
      gap  = (n >= 150 && n < 180) ? 0 : $urandom_range(0, 18);
      pick = $urandom_range(0, 99);
      if (pick < 10)
        t = make_transaction(cmd_t'($urandom_range(0, 1)), {$urandom, $urandom},
                             4'($urandom));
      else
        t = make_transaction(cmd_t'(pick < 50), hash_pool[$urandom_range(0, 23)],
                             (pick < 45) ? 4'($urandom_range(1, 8)) : 4'($urandom));
      send_transaction(t, gap);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d transactions: lookups and records over a small key pool,", sent);
    $display("covering misses, hits, hit counting and replacement in a full table.");
    if (fail_count == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
